// ===== hw/rtl/grc_pkg.sv =====
// Package for the grid ray caster: geometry constants and shared types.
// No dependencies.
package grc_pkg;
  localparam int SCREEN_WIDTH  = 96;
  localparam int SCREEN_HEIGHT = 64;
  localparam int MAP_SIDE      = 8;
  localparam int MAX_STEPS     = 16;

  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_BITMAP  = 3'd6;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ===== hw/rtl/grc_div.sv =====
// Radix-2 restoring divider, unsigned 32 by 32, one quotient bit a cycle.
// Uses grc_pkg.
module grc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        num,
  input  logic [31:0]        den,
  output grc_pkg::div_ctl_t  ctl,
  output logic [31:0]        quo
);
  import grc_pkg::*;

  logic [31:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[31]} - {1'b0, d_r};
    if (start) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial; q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[31]}; q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (start) d_r <= den;
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign quo = q_r;
endmodule

// ===== hw/rtl/grid_raycast_column.sv =====
// Grid ray caster, one screen column per word; uses grc_pkg and grc_div.
// Work per column: three divisions on the shared divider (the last one only when
// the wall distance is positive) and 1 to 16 DDA steps; a ray with a zero x or y
// component is skipped. One column at a time.
// in_stall is high while a column is in work or its result waits.
// Reset (synchronous, rst_n low) loads the default view registers and idles.
module grid_raycast_column (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  in_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_draw_valid,
  output logic [5:0]  out_span_start,
  output logic [5:0]  out_span_end,
  output logic        out_hit_side,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import grc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CAM, S_RAY, S_DX, S_DXW, S_DY, S_DYW, S_SD, S_WALK, S_DIST, S_HW,
    S_SPAN, S_OUT
  } state_t;

  state_t state_r;
  logic [10:0] pos_x_r, pos_y_r;
  logic signed [10:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [63:0] bitmap_r;

  logic [6:0] col_r;
  logic signed [9:0] cam_r;
  logic signed [23:0] rdx_r, rdy_r;
  logic [16:0] ddx_r, ddy_r;
  logic signed [26:0] sdx_r, sdy_r;
  logic signed [4:0] cx_r, cy_r;
  logic side_r;
  logic [4:0] n_r;
  logic [7:0] lh_r;
  logic signed [26:0] dist_r;

  logic div_start;
  logic [31:0] div_num, div_den, div_q;
  div_ctl_t div_ctl;

  grc_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
                 .den(div_den), .ctl(div_ctl), .quo(div_q));

  // |ray| stays well under 2^23
  function automatic logic [31:0] mag(input logic signed [23:0] v);
    logic signed [23:0] a;
    a = (v < 0) ? -v : v;
    return {8'd0, a};
  endfunction

  // floor((a*b)/256) for signed product
  function automatic logic signed [26:0] fmul(input logic signed [26:0] p);
    return p >>> 8;
  endfunction

  logic signed [4:0] ncx, ncy;
  logic [5:0] bit_idx;
  logic wall;
  logic signed [26:0] sdx_a, sdy_a;
  logic signed [9:0] half;
  logic signed [9:0] st, en;

  always_comb begin
    ncx = cx_r; ncy = cy_r;
    if (sdx_r < sdy_r) ncx = cx_r + ((rdx_r < 0) ? -5'sd1 : 5'sd1);
    else               ncy = cy_r + ((rdy_r < 0) ? -5'sd1 : 5'sd1);
    bit_idx = {ncx[2:0], ncy[2:0]};
    wall = (ncx < 0) || (ncy < 0) || (ncx >= MAP_SIDE) || (ncy >= MAP_SIDE) ||
           bitmap_r[bit_idx];
    sdx_a = fmul($signed({18'd0, (rdx_r < 0) ? {1'b0, pos_x_r[7:0]}
                                             : 9'd256 - {1'b0, pos_x_r[7:0]}}) *
                 $signed({10'd0, ddx_r}));
    sdy_a = fmul($signed({18'd0, (rdy_r < 0) ? {1'b0, pos_y_r[7:0]}
                                             : 9'd256 - {1'b0, pos_y_r[7:0]}}) *
                 $signed({10'd0, ddy_r}));
    half = $signed({2'd0, lh_r}) >>> 1;
    st = 10'sd32 - half; if (st < 0) st = '0;
    en = half + 10'sd32; if (en > 10'sd63) en = 10'sd63;
    if (st > en) st = en;
    div_start = 1'b0; div_num = 32'd65536; div_den = mag(rdx_r);
    case (state_r)
      S_DX: div_start = 1'b1;
      S_DY: begin div_start = 1'b1; div_den = mag(rdy_r); end
      S_HW: if (!div_ctl.busy && !div_ctl.done && dist_r > 0) begin
        div_start = 1'b1; div_num = 32'(SCREEN_HEIGHT) << 16; div_den = {5'd0, dist_r};
      end
      default: ;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid <= 1'b0;
      pos_x_r <= 11'd1536; pos_y_r <= 11'd1536;
      dir_x_r <= -11'sd256; dir_y_r <= '0; plane_x_r <= '0; plane_y_r <= 11'sd169;
      bitmap_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POS_X:   pos_x_r <= cfg_data[10:0];
          REG_POS_Y:   pos_y_r <= cfg_data[10:0];
          REG_DIR_X:   dir_x_r <= cfg_data[10:0];
          REG_DIR_Y:   dir_y_r <= cfg_data[10:0];
          REG_PLANE_X: plane_x_r <= cfg_data[10:0];
          REG_PLANE_Y: plane_y_r <= cfg_data[10:0];
          REG_BITMAP:  bitmap_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_valid) begin col_r <= in_column; state_r <= S_CAM; end
        S_CAM: begin
          // floor(col*256/96) = (col*8)/3 via reciprocal, doubled by the shift
          cam_r <= $signed({9'((32'(col_r) * 32'd8 * 32'd21846) >> 16), 1'b0}
                           - 10'd256);
          state_r <= S_RAY;
        end
        S_RAY: begin
          rdx_r <= 24'(dir_x_r) + 24'(fmul(27'(plane_x_r) * 27'(cam_r)));
          rdy_r <= 24'(dir_y_r) + 24'(fmul(27'(plane_y_r) * 27'(cam_r)));
          state_r <= S_DX;
        end
        S_DX: begin
          if (rdx_r == 0 || rdy_r == 0) begin
            out_draw_valid <= 1'b0; out_span_start <= '0; out_span_end <= '0;
            out_hit_side <= 1'b0; out_valid <= 1'b1; state_r <= S_OUT;
          end else state_r <= S_DXW;
        end
        S_DXW: if (div_ctl.done) begin
          ddx_r <= (div_q > 32'd65535) ? 17'd65535 : div_q[16:0];
          state_r <= S_DY;
        end
        S_DY: state_r <= S_DYW;
        S_DYW: if (div_ctl.done) begin
          ddy_r <= (div_q > 32'd65535) ? 17'd65535 : div_q[16:0];
          state_r <= S_SD;
        end
        S_SD: begin
          sdx_r <= sdx_a; sdy_r <= sdy_a;
          cx_r <= $signed({2'd0, pos_x_r[10:8]}); cy_r <= $signed({2'd0, pos_y_r[10:8]});
          n_r <= '0; state_r <= S_WALK;
        end
        S_WALK: begin
          if (sdx_r < sdy_r) begin sdx_r <= sdx_r + $signed({10'd0, ddx_r}); side_r <= 1'b0; end
          else begin sdy_r <= sdy_r + $signed({10'd0, ddy_r}); side_r <= 1'b1; end
          cx_r <= ncx; cy_r <= ncy; n_r <= n_r + 5'd1;
          if (wall || n_r == 5'(MAX_STEPS - 1)) state_r <= S_DIST;
        end
        S_DIST: begin
          dist_r <= side_r ? sdy_r - $signed({10'd0, ddy_r})
                           : sdx_r - $signed({10'd0, ddx_r});
          state_r <= S_HW;
        end
        S_HW: begin
          if (dist_r <= 0) begin lh_r <= 8'd128; state_r <= S_SPAN; end
          else if (div_ctl.done) begin
            lh_r <= (div_q[31:8] > 24'd128) ? 8'd128 : div_q[15:8];
            state_r <= S_SPAN;
          end
        end
        S_SPAN: begin
          out_draw_valid <= 1'b1; out_span_start <= st[5:0]; out_span_end <= en[5:0];
          out_hit_side <= side_r; out_valid <= 1'b1; state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) begin out_valid <= 1'b0; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/grc_checker.sv =====
// Port-level checks for the ray caster.
// Bound to grid_raycast_column; uses no package items.
module grc_props (
  input logic clk, rst_n, in_stall, out_valid, out_stall,
  input logic out_draw_valid, out_hit_side, cfg_ready,
  input logic [5:0] out_span_start, out_span_end
);
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result shown while idle");
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_span_start <= out_span_end) else $error("span order");
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_draw_valid) |-> (out_span_end == 0 && !out_hit_side))
    else $error("skipped ray fields");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_span_end))
    else $error("stalled word changed");
  // config is taken only while no column is in work
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready != in_stall) else $error("config ready while busy");
endmodule

bind grid_raycast_column grc_props u_chk (.*);
